### hw/rtl/palette_color_interning_core_macros.svh
// ----------------------------------------------------------------------------
// Palette color interning - assertion macros
// Shared concurrent assertion forms; the including module supplies clk and
// arst_n.
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_INTERNING_CORE_MACROS_SVH
`define PALETTE_COLOR_INTERNING_CORE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define PCI_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PCI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pci_pkg.sv
// ----------------------------------------------------------------------------
// Palette color interning - package
// Sizes, register indexes, op and outcome codes, and the types passed
// between the sequencer and the distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W         = $clog2(PALETTE_DEPTH);
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

	localparam int CH_W   = 8;
	localparam int RGB_W  = 3 * CH_W;
	localparam int SQ_W   = 2 * CH_W;
	localparam int DIST_W = SQ_W + 2;

	localparam int SLOT_W = 8;
	localparam int USED_W = 9;
	localparam int OP_W   = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_BG_RED   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BG_GREEN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BG_BLUE  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = CFG_IDX_W'(3);

	localparam logic [CFG_DATA_W-1:0] BUDGET_RESET = CFG_DATA_W'(256);
	localparam logic [CFG_DATA_W-1:0] BUDGET_MIN   = CFG_DATA_W'(2);
	localparam logic [CFG_DATA_W-1:0] BUDGET_MAX   = CFG_DATA_W'(PALETTE_DEPTH);

	localparam logic [OP_W-1:0] OP_INTERN  = OP_W'(0);
	localparam logic [OP_W-1:0] OP_RESTART = OP_W'(1);

	typedef enum logic [2:0] {
		OUT_EXACT       = 3'd0,
		OUT_APPENDED    = 3'd1,
		OUT_NEAREST     = 3'd2,
		OUT_RESTARTED   = 3'd3,
		OUT_READ_OK     = 3'd4,
		OUT_READ_UNUSED = 3'd5
	} outcome_t;

	// One palette entry entering the distance unit.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic [RGB_W-1:0] rgb;
	} dist_req_t;

	// Running result of the scan.
	typedef struct packed {
		logic             busy;
		logic             exact;
		logic [IDX_W-1:0] nearest_index;
		logic [RGB_W-1:0] nearest_rgb;
	} dist_status_t;

endpackage

`default_nettype wire

### hw/rtl/pci_ram.sv
// ----------------------------------------------------------------------------
// Palette color interning - generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pci_dist.sv
// ----------------------------------------------------------------------------
// Palette color interning - distance unit
// Two-stage squared RGB distance and running minimum; first strict minimum
// wins, so ties keep the lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic [pci_pkg::RGB_W-1:0]  color,
	input  pci_pkg::dist_req_t         req,
	output pci_pkg::dist_status_t      status
);
	import pci_pkg::*;

	logic              valid_s1;
	logic [IDX_W-1:0]  index_s1;
	logic [RGB_W-1:0]  rgb_s1;
	logic [SQ_W-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  nearest_index_q;
	logic [RGB_W-1:0]  nearest_rgb_q;
	logic [DIST_W-1:0] sum;

	function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	// stage 1: per-channel squares
	always_ff @(posedge clk) begin
		index_s1 <= req.index;
		rgb_s1   <= req.rgb;
		sq_r_s1  <= chan_sq(req.rgb[3*CH_W-1:2*CH_W], color[3*CH_W-1:2*CH_W]);
		sq_g_s1  <= chan_sq(req.rgb[2*CH_W-1:CH_W], color[2*CH_W-1:CH_W]);
		sq_b_s1  <= chan_sq(req.rgb[CH_W-1:0], color[CH_W-1:0]);
	end

	assign sum = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);

	// stage 2: sum and compare against the running best
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			best_q   <= '1;
		end else begin
			valid_s1 <= req.valid;
			if (clear) begin
				best_q <= '1;
			end else if (valid_s1 && (sum < best_q)) begin
				best_q <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && valid_s1 && (sum < best_q)) begin
			nearest_index_q <= index_s1;
			nearest_rgb_q   <= rgb_s1;
		end
	end

	assign status = '{
		busy:          valid_s1,
		exact:         (best_q == '0),
		nearest_index: nearest_index_q,
		nearest_rgb:   nearest_rgb_q
	};

endmodule

`default_nettype wire

### hw/rtl/palette_color_interning_core.sv
// ----------------------------------------------------------------------------
// Palette color interning core
// Palette of up to 256 RGB entries with exact-match, append and nearest-color
// lookup, restart to background, and entry read-back.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_ready is high only while the core is
// idle. An intern item scans the used entries through the palette RAM's
// single read port at one entry per cycle, then waits in a drain state for
// the RAM read and the two-stage distance unit to empty, then decides in
// the finish state and returns to idle. A restart goes straight to the
// finish state; a read of a used entry issues the RAM read, waits for the
// data and then finishes, and a read of an unused entry goes straight to
// finish. Results sit in an output register, so the next item is taken
// while a result waits; the finish state holds until that register is
// free. Entry zero lives in flops (reset to the background), entries one
// and up live in the RAM and are only read after they were appended, so no
// clearing pass is needed. Configuration writes land at once and must only
// happen while the core is idle; background changes reach entry zero on the
// next restart, and the budget is clamped to 2..256.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_color_interning_core_macros.svh"

module palette_color_interning_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [pci_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pci_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pci_pkg::OP_W-1:0]        op,
	input  logic [pci_pkg::CH_W-1:0]        color_red,
	input  logic [pci_pkg::CH_W-1:0]        color_green,
	input  logic [pci_pkg::CH_W-1:0]        color_blue,
	input  logic [pci_pkg::SLOT_W-1:0]      read_slot,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pci_pkg::SLOT_W-1:0]      palette_index,
	output logic [pci_pkg::CH_W-1:0]        entry_red,
	output logic [pci_pkg::CH_W-1:0]        entry_green,
	output logic [pci_pkg::CH_W-1:0]        entry_blue,
	output logic [2:0]                      outcome,
	output logic [pci_pkg::USED_W-1:0]      entries_used
);
	import pci_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RD_ISSUE,
		ST_RD_WAIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		KIND_INTERN,
		KIND_RESTART,
		KIND_READ
	} kind_t;

	// control state
	state_t           state_q;
	kind_t            kind_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] used_q;
	logic [RGB_W-1:0] entry0_q;
	logic             out_valid_q;
	logic             rd_valid_s1;

	// configuration registers
	logic [CH_W-1:0]       bg_red_q, bg_green_q, bg_blue_q;
	logic [CFG_DATA_W-1:0] budget_q;

	// payload registers
	logic [RGB_W-1:0]  color_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] res_index_q;
	logic [RGB_W-1:0]  res_rgb_q;
	outcome_t          res_outcome_q;
	logic [IDX_W-1:0]  rd_index_s1;
	logic [SLOT_W-1:0] out_index_q;
	logic [RGB_W-1:0]  out_rgb_q;
	outcome_t          out_outcome_q;
	logic [CNT_W-1:0]  out_used_q;

	// datapath
	logic              in_xfer;
	logic              out_free;
	logic              scan_last;
	logic              slot_used;
	logic [CNT_W-1:0]  budget_clamped;
	logic [RGB_W-1:0]  bg_rgb;
	logic [RGB_W-1:0]  in_rgb;
	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [RGB_W-1:0]  ram_rdata;
	logic [RGB_W-1:0]  rd_entry;
	logic              dist_clear;
	dist_req_t         dist_req;
	dist_status_t      dist_status;

	// decision of the finish cycle
	logic [SLOT_W-1:0] fin_index;
	logic [RGB_W-1:0]  fin_rgb;
	outcome_t          fin_outcome;
	logic [CNT_W-1:0]  fin_used;
	logic              fin_append;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign bg_rgb = {bg_red_q, bg_green_q, bg_blue_q};
	assign in_rgb = {color_red, color_green, color_blue};

	// last entry of the scan is the one just below the used count
	assign scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == used_q);
	assign slot_used = ({1'b0, read_slot} < USED_W'(used_q));

	// budget clamped into 2..depth
	always_comb begin
		if (budget_q < BUDGET_MIN) begin
			budget_clamped = CNT_W'(BUDGET_MIN);
		end else if (budget_q > BUDGET_MAX) begin
			budget_clamped = CNT_W'(BUDGET_MAX);
		end else begin
			budget_clamped = CNT_W'(budget_q);
		end
	end

	// ------------------------------------------------------------------
	// Palette RAM: entries one and up; entry zero is entry0_q
	// ------------------------------------------------------------------
	assign ram_re    = (state_q == ST_SCAN) || (state_q == ST_RD_ISSUE);
	assign ram_raddr = (state_q == ST_SCAN) ? scan_idx_q : slot_q[IDX_W-1:0];
	assign ram_we    = (state_q == ST_FINISH) && out_free && fin_append;

	pci_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (used_q[IDX_W-1:0]),
		.wdata (color_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = (rd_index_s1 == '0) ? entry0_q : ram_rdata;

	// ------------------------------------------------------------------
	// Distance / minimum unit
	// ------------------------------------------------------------------
	assign dist_clear = in_xfer && (op == OP_INTERN);
	assign dist_req   = '{valid: rd_valid_s1, index: rd_index_s1, rgb: rd_entry};

	pci_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (dist_clear),
		.color  (color_q),
		.req    (dist_req),
		.status (dist_status)
	);

	// ------------------------------------------------------------------
	// Finish: pick the result and the state update
	// ------------------------------------------------------------------
	always_comb begin
		fin_index   = res_index_q;
		fin_rgb     = res_rgb_q;
		fin_outcome = res_outcome_q;
		fin_used    = used_q;
		fin_append  = 1'b0;
		unique case (kind_q)
			KIND_INTERN: begin
				if (dist_status.exact) begin
					fin_index   = SLOT_W'(dist_status.nearest_index);
					fin_rgb     = dist_status.nearest_rgb;
					fin_outcome = OUT_EXACT;
				end else if (used_q < budget_clamped) begin
					fin_index   = SLOT_W'(used_q);
					fin_rgb     = color_q;
					fin_outcome = OUT_APPENDED;
					fin_used    = used_q + CNT_W'(1);
					fin_append  = 1'b1;
				end else begin
					fin_index   = SLOT_W'(dist_status.nearest_index);
					fin_rgb     = dist_status.nearest_rgb;
					fin_outcome = OUT_NEAREST;
				end
			end
			KIND_RESTART: begin
				fin_index   = '0;
				fin_rgb     = bg_rgb;
				fin_outcome = OUT_RESTARTED;
				fin_used    = CNT_W'(1);
			end
			default: begin
				// read: result prepared in res_* already
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_INTERN;
			scan_idx_q  <= '0;
			used_q      <= CNT_W'(1);
			entry0_q    <= '0;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			// a new result loads the output register, else a transfer empties it
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						scan_idx_q <= '0;
						if (op == OP_RESTART) begin
							kind_q  <= KIND_RESTART;
							state_q <= ST_FINISH;
						end else if (op == OP_INTERN) begin
							kind_q  <= KIND_INTERN;
							state_q <= ST_SCAN;
						end else begin
							kind_q  <= KIND_READ;
							state_q <= slot_used ? ST_RD_ISSUE : ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for RAM read and both distance stages to empty
					if (!rd_valid_s1 && !dist_status.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						used_q <= fin_used;
						if (kind_q == KIND_RESTART) begin
							entry0_q <= bg_rgb;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_index_s1 <= ram_raddr;
		end
		if (in_xfer) begin
			color_q     <= in_rgb;
			slot_q      <= read_slot;
			res_index_q <= read_slot;
			// unused slot reads back as zero
			res_rgb_q     <= '0;
			res_outcome_q <= OUT_READ_UNUSED;
		end
		if (state_q == ST_RD_WAIT) begin
			res_rgb_q     <= rd_entry;
			res_outcome_q <= OUT_READ_OK;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_index_q   <= fin_index;
			out_rgb_q     <= fin_rgb;
			out_outcome_q <= fin_outcome;
			out_used_q    <= fin_used;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_red_q   <= '0;
			bg_green_q <= '0;
			bg_blue_q  <= '0;
			budget_q   <= BUDGET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BG_RED:   bg_red_q   <= cfg_data[CH_W-1:0];
				REG_BG_GREEN: bg_green_q <= cfg_data[CH_W-1:0];
				REG_BG_BLUE:  bg_blue_q  <= cfg_data[CH_W-1:0];
				REG_BUDGET:   budget_q   <= cfg_data;
			endcase
		end
	end

	// outputs
	assign out_valid     = out_valid_q;
	assign palette_index = out_index_q;
	assign entry_red     = out_rgb_q[3*CH_W-1:2*CH_W];
	assign entry_green   = out_rgb_q[2*CH_W-1:CH_W];
	assign entry_blue    = out_rgb_q[CH_W-1:0];
	assign outcome       = out_outcome_q;
	assign entries_used  = USED_W'(out_used_q);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`PCI_ASSERT_IMPLY(a_idle_drained, state_q == ST_IDLE, !rd_valid_s1 && !dist_status.busy, "scan pipeline busy while idle")

	`PCI_ASSERT_IMPLY(a_append_in_budget, ram_we, (used_q < budget_clamped) && (kind_q == KIND_INTERN) && (used_q != '0), "append beyond budget")

	`PCI_ASSERT_IMPLY(a_exact_matches, (state_q == ST_FINISH) && (kind_q == KIND_INTERN) && dist_status.exact, dist_status.nearest_rgb == color_q, "exact match entry differs from color")

	`PCI_ASSERT_IMPLY(a_used_step, used_q != $past(used_q), (used_q == $past(used_q) + CNT_W'(1)) || (used_q == CNT_W'(1)), "used count jumped")

endmodule

`default_nettype wire
